>>> sv/assert_macros.svh
// assertion macros for the rotation to euler block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> sv/rme_pkg.sv
// shared types and constants for the rotation to euler block
`default_nettype none
package rme_pkg;
    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r22;
    } rme_in_t;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic               gimbal_lock;
    } rme_out_t;

    localparam int TABLE_LEN = 24;
    localparam int CW = 28;   // cordic x/y width
    localparam int AW = 23;   // angle accumulator width
    localparam logic signed [AW-1:0] HALF_PI_Q20 = 23'sd1647099;
    localparam logic signed [AW-1:0] ANGLE_MAX = 23'sd25736;

    function automatic logic signed [AW-1:0] atan_tab(input int i);
        logic signed [AW-1:0] r;
        case (i)
            0: r = 23'sd823550;
            1: r = 23'sd486171;
            2: r = 23'sd256879;
            3: r = 23'sd130396;
            4: r = 23'sd65451;
            5: r = 23'sd32757;
            6: r = 23'sd16383;
            7: r = 23'sd8192;
            8: r = 23'sd4096;
            9: r = 23'sd2048;
            10: r = 23'sd1024;
            11: r = 23'sd512;
            12: r = 23'sd256;
            13: r = 23'sd128;
            14: r = 23'sd64;
            15: r = 23'sd32;
            16: r = 23'sd16;
            17: r = 23'sd8;
            18: r = 23'sd4;
            19: r = 23'sd2;
            20: r = 23'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

>>> sv/rotation_matrix_to_euler.sv
// rotation matrix to euler angles, top level
// stages: 1 input + 17 sqrt + CORDIC_STEPS+1 cordic + 1 output register = 34 stages
// at the default of 14 steps; CORDIC_STEPS is capped at 24 cordic steps
// throughput: one transaction per cycle; the whole pipe freezes on a stall
// reset: aresetn synchronous active low clears valid bits and the threshold
`default_nettype none
`include "assert_macros.svh"
module rotation_matrix_to_euler import rme_pkg::*; #(
    parameter int CORDIC_STEPS = 14
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire rme_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output rme_out_t      m_data,
    input  wire logic     cfg_we,
    input  wire logic [14:0] cfg_data
);
    localparam int NS  = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int LAT = 1 + 17 + NS + 1 + 1;   // input reg, sqrt, cordic, output reg

    logic [14:0] thr_reg;
    logic        en;
    logic [LAT-1:0] vld_reg;

    // pipe advances whenever the output slot is free or being taken
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) thr_reg <= '0;
        else if (cfg_we) thr_reg <= cfg_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[LAT-2:0], s_valid};
    end
    assign m_valid = vld_reg[LAT-1];

    // input register and squared sum
    rme_in_t in_reg;
    always_ff @(posedge aclk) begin
        if (en) in_reg <= s_data;
    end
    logic [32:0] sq;
    always_comb begin
        sq = 33'(unsigned'(32'(in_reg.r22 * in_reg.r22)))
           + 33'(unsigned'(32'(in_reg.r12 * in_reg.r12)));
    end

    // sqrt stage carries the matrix along
    logic [16:0] cy;
    rme_in_t     sq_tag;
    rme_sqrt #(.TAGW($bits(rme_in_t))) u_sqrt (
        .aclk, .en, .sq_in(sq), .tag_in(in_reg),
        .root_out(cy), .tag_out(sq_tag)
    );

    // branch select, three cordic lanes in parallel
    logic lock;
    logic signed [17:0] xa_y, xa_x, za_y, za_x, ya_y, ya_x;
    always_comb begin
        lock = cy <= {2'b0, thr_reg};
        xa_y = -18'(sq_tag.r12);
        xa_x = 18'(sq_tag.r22);
        ya_y = 18'(sq_tag.r02);
        ya_x = signed'({1'b0, cy});
        za_y = lock ? -18'(sq_tag.r10) : -18'(sq_tag.r01);
        za_x = lock ?  18'(sq_tag.r11) :  18'(sq_tag.r00);
    end

    logic signed [15:0] ax, ay, az;
    logic lock_x, lock_y, lock_z;
    rme_cordic #(.STEPS(CORDIC_STEPS), .TAGW(1)) u_cx (
        .aclk, .en, .y_in(xa_y), .x_in(xa_x), .tag_in(lock),
        .ang_out(ax), .tag_out(lock_x));
    rme_cordic #(.STEPS(CORDIC_STEPS), .TAGW(1)) u_cy (
        .aclk, .en, .y_in(ya_y), .x_in(ya_x), .tag_in(lock),
        .ang_out(ay), .tag_out(lock_y));
    rme_cordic #(.STEPS(CORDIC_STEPS), .TAGW(1)) u_cz (
        .aclk, .en, .y_in(za_y), .x_in(za_x), .tag_in(lock),
        .ang_out(az), .tag_out(lock_z));

    // output register
    rme_out_t out_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.angle_x     <= lock_x ? '0 : ax;
            out_reg.angle_y     <= ay;
            out_reg.angle_z     <= az;
            out_reg.gimbal_lock <= lock_x;
        end
    end
    assign m_data = out_reg;

    // stalled result holds
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_data) && m_valid,
        "result changed under stall")
    // locked results have zero x angle
    `ASSERT_IMPL(a_lockx, aclk, aresetn, m_valid && m_data.gimbal_lock |-> m_data.angle_x == 0,
        "x angle not zero in gimbal lock")
    // lock tag consistent across lanes for a valid transaction
    `ASSERT_IMPL(a_lanes, aclk, aresetn, vld_reg[LAT-2] |-> (lock_x == lock_y) && (lock_y == lock_z),
        "cordic lanes out of step")
endmodule
`default_nettype wire

>>> sv/rme_sqrt.sv
// pipelined bitwise square root, one result bit per stage
`default_nettype none
module rme_sqrt import rme_pkg::*; #(
    parameter int TAGW = 1
) (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [32:0]     sq_in,
    input  wire logic [TAGW-1:0] tag_in,
    output logic      [16:0]     root_out,
    output logic      [TAGW-1:0] tag_out
);
    // 17 stages; rem/res as in the restoring algorithm with bit = 4^(16-k)
    localparam int N = 17;
    logic [33:0] rem_reg [N+1];
    logic [33:0] res_reg [N+1];
    logic [TAGW-1:0] tag_reg [N+1];

    always_comb begin
        rem_reg[0] = {1'b0, sq_in};
        res_reg[0] = '0;
        tag_reg[0] = tag_in;
    end

    for (genvar k = 0; k < N; k++) begin : g_st
        localparam logic [33:0] BIT = 34'd1 << (2 * (N - 1 - k));
        logic [33:0] rem_next, res_next;
        always_comb begin
            if (rem_reg[k] >= res_reg[k] + BIT) begin
                rem_next = rem_reg[k] - (res_reg[k] + BIT);
                res_next = (res_reg[k] >> 1) + BIT;
            end else begin
                rem_next = rem_reg[k];
                res_next = res_reg[k] >> 1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= rem_next;
                res_reg[k+1] <= res_next;
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign root_out = res_reg[N][16:0];
    assign tag_out  = tag_reg[N];
endmodule
`default_nettype wire

>>> sv/rme_cordic.sv
// pipelined vectoring cordic arctangent, one iteration per stage
`default_nettype none
module rme_cordic import rme_pkg::*; #(
    parameter int STEPS = 14,
    parameter int TAGW  = 1
) (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic signed [17:0] y_in,
    input  wire logic signed [17:0] x_in,
    input  wire logic [TAGW-1:0]    tag_in,
    output logic signed [15:0]      ang_out,
    output logic [TAGW-1:0]         tag_out
);
    localparam int NS = (STEPS < TABLE_LEN) ? STEPS : TABLE_LEN;

    logic signed [CW-1:0] x_reg [NS+1];
    logic signed [CW-1:0] y_reg [NS+1];
    logic signed [AW-1:0] a_reg [NS+1];
    logic                 z_reg [NS+1];
    logic [TAGW-1:0]      t_reg [NS+1];
    logic signed [CW-1:0] xs, ys;
    logic zero_in;

    // prerotation into the right half plane
    always_comb begin
        xs = CW'(x_in) <<< 8;
        ys = CW'(y_in) <<< 8;
        zero_in = (x_in == '0) && (y_in == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg[0] <= zero_in;
            t_reg[0] <= tag_in;
            if (xs < 0) begin
                if (ys >= 0) begin
                    x_reg[0] <= ys; y_reg[0] <= -xs; a_reg[0] <= HALF_PI_Q20;
                end else begin
                    x_reg[0] <= -ys; y_reg[0] <= xs; a_reg[0] <= -HALF_PI_Q20;
                end
            end else begin
                x_reg[0] <= xs; y_reg[0] <= ys; a_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_it
        always_ff @(posedge aclk) begin
            if (en) begin
                z_reg[i+1] <= z_reg[i];
                t_reg[i+1] <= t_reg[i];
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] + atan_tab(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    a_reg[i+1] <= a_reg[i] - atan_tab(i);
                end
            end
        end
    end

    logic signed [AW-1:0] rnd;
    always_comb begin
        rnd = (a_reg[NS] + AW'(64)) >>> 7;
        if (z_reg[NS])            ang_out = '0;
        else if (rnd > ANGLE_MAX) ang_out = 16'(ANGLE_MAX);
        else if (rnd < -ANGLE_MAX) ang_out = 16'(-ANGLE_MAX);
        else                      ang_out = 16'(rnd);
    end
    assign tag_out = t_reg[NS];
endmodule
`default_nettype wire

>>> test/tb_rotation_matrix_to_euler.sv
// testbench for the rotation matrix to euler angles block
`timescale 1ns / 100ps
module tb_rotation_matrix_to_euler;
    import rme_pkg::*;

    localparam int STEPS = 14;
    localparam int LATENCY = 40;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint HALF_PI = 1647099;
    localparam longint ANG_SAT = 25736;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    rme_in_t s_data;
    logic m_valid;
    logic m_ready;
    rme_out_t m_data;
    logic cfg_we;
    logic [14:0] cfg_data;

    rotation_matrix_to_euler #(.CORDIC_STEPS(STEPS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    // matrices waiting to be sent, and angles waiting to come back
    rme_in_t matrix_q[$];
    rme_out_t angles_q[$];
    logic [14:0] lock_threshold;
    int errors;
    longint cycles;
    bit no_idle;
    bit hold_send;
    int send_gap;
    int recv_gap;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // floor division by a power of two
    function automatic longint fshift(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint atan_tbl(int i);
        longint t[21] = '{823550, 486171, 256879, 130396, 65451, 32757, 16383, 8192,
                          4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
        if (i > 20) return 0;
        return t[i];
    endfunction

    // exact floor square root
    function automatic longint root_floor(longint v);
        longint res;
        longint bitv;
        res = 0;
        bitv = longint'(1) << 32;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // vectoring arctangent, radians * 8192, saturated
    function automatic logic signed [15:0] vec_angle(longint yi, longint xi);
        longint x;
        longint y;
        longint ang;
        longint t;
        longint xs;
        longint ys;
        if (xi == 0 && yi == 0) return '0;
        x = xi * 256;
        y = yi * 256;
        ang = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; ang = HALF_PI;
            end else begin
                t = x; x = -y; y = t; ang = -HALF_PI;
            end
        end
        for (int i = 0; i < STEPS && i < 24; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y > 0) begin
                x += ys; y -= xs; ang += atan_tbl(i);
            end else begin
                x -= ys; y += xs; ang -= atan_tbl(i);
            end
        end
        ang = fshift(ang + 64, 7);
        if (ang > ANG_SAT) ang = ANG_SAT;
        if (ang < -ANG_SAT) ang = -ANG_SAT;
        return ang[15:0];
    endfunction

    function automatic rme_out_t euler_of(rme_in_t m, logic [14:0] thr);
        rme_out_t o;
        longint cy;
        longint a;
        longint b;
        a = longint'(m.r22);
        b = longint'(m.r12);
        cy = root_floor(a * a + b * b);
        o.gimbal_lock = (cy <= longint'(thr));
        o.angle_y = vec_angle(longint'(m.r02), cy);
        if (!o.gimbal_lock) begin
            o.angle_x = vec_angle(-longint'(m.r12), longint'(m.r22));
            o.angle_z = vec_angle(-longint'(m.r01), longint'(m.r00));
        end else begin
            o.angle_x = '0;
            o.angle_z = vec_angle(-longint'(m.r10), longint'(m.r11));
        end
        return o;
    endfunction

    function automatic logic signed [15:0] rand_entry();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return 16'($urandom);               // full 16-bit range
        if (k == 1) return 16'sd16384;
        if (k == 2) return -16'sd16384;
        if (k == 3) return '0;
        if (k < 6) return 16'($urandom_range(0, 400)) - 16'sd200;
        return 16'($urandom_range(0, 32768)) - 16'sd16384;
    endfunction

    function automatic rme_in_t rand_matrix();
        rme_in_t m;
        m.r00 = rand_entry(); m.r01 = rand_entry(); m.r02 = rand_entry();
        m.r10 = rand_entry(); m.r11 = rand_entry();
        m.r12 = rand_entry(); m.r22 = rand_entry();
        // near gimbal lock: small cy
        if ($urandom_range(0, 5) == 0) begin
            m.r12 = 16'($urandom_range(0, 64)) - 16'sd32;
            m.r22 = 16'($urandom_range(0, 64)) - 16'sd32;
        end
        return m;
    endfunction

    function automatic rme_in_t flat_matrix(logic signed [15:0] v);
        rme_in_t m;
        m.r00 = v; m.r01 = v; m.r02 = v; m.r10 = v; m.r11 = v; m.r12 = v; m.r22 = v;
        return m;
    endfunction

    // driver: payload held until the transaction is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                angles_q.insert(angles_q.size(), euler_of(s_data, lock_threshold));
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(1, 15);
                    s_valid <= 1'b0;
                end else if (matrix_q.size() > 0 && !hold_send) begin
                    s_data <= matrix_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each returned transaction with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (angles_q.size() == 0) begin
                    $display("%0t unexpected result %h", $time, m_data);
                    errors++;
                end else begin
                    rme_out_t e;
                    e = angles_q.pop_front();
                    if (e.angle_x !== m_data.angle_x)
                        $display("%0t angle_x expected %0d got %0d", $time, e.angle_x,
                                 m_data.angle_x);
                    if (e.angle_y !== m_data.angle_y)
                        $display("%0t angle_y expected %0d got %0d", $time, e.angle_y,
                                 m_data.angle_y);
                    if (e.angle_z !== m_data.angle_z)
                        $display("%0t angle_z expected %0d got %0d", $time, e.angle_z,
                                 m_data.angle_z);
                    if (e.gimbal_lock !== m_data.gimbal_lock)
                        $display("%0t gimbal_lock expected %0b got %0b", $time,
                                 e.gimbal_lock, m_data.gimbal_lock);
                    if (e !== m_data) errors++;
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(1, 15);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_rotation_matrix_to_euler NOT OK");
            $finish;
        end
    end

    task automatic drain();
        while (matrix_q.size() > 0 || s_valid || angles_q.size() > 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    task automatic set_threshold(logic [14:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        lock_threshold <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [14:0] thr_list[5];
        rme_in_t m;
        thr_list = '{15'd0, 15'd16384, 15'd32767, 15'd200, 15'd8000};
        errors = 0;
        cycles = 0;
        no_idle = 0;
        hold_send = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        lock_threshold = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, zero vectors, negative x with zero y, full-range entries
        matrix_q.insert(matrix_q.size(), flat_matrix(16'sd0));
        matrix_q.insert(matrix_q.size(), flat_matrix(16'sd16384));
        matrix_q.insert(matrix_q.size(), flat_matrix(-16'sd16384));
        matrix_q.insert(matrix_q.size(), flat_matrix(16'sh8000));
        matrix_q.insert(matrix_q.size(), flat_matrix(16'sd32767));
        matrix_q.insert(matrix_q.size(), flat_matrix(16'sh5555));
        matrix_q.insert(matrix_q.size(), flat_matrix(16'shAAAA));
        m = flat_matrix(16'sd0);
        m.r00 = -16'sd16384; m.r22 = -16'sd16384; m.r11 = -16'sd16384;
        matrix_q.insert(matrix_q.size(), m);         // angle of exactly pi
        m = flat_matrix(16'sd0);
        m.r02 = 16'sd16384; m.r10 = 16'sd16384; m.r11 = 16'sd1;
        matrix_q.insert(matrix_q.size(), m);         // locked, pure pitch
        m = flat_matrix(16'sd0);
        m.r12 = 16'sh8000; m.r22 = 16'sh8000; m.r01 = 16'sh8000;
        matrix_q.insert(matrix_q.size(), m);         // largest root sum
        m = flat_matrix(16'sd1);
        m.r12 = 16'sd0;
        matrix_q.insert(matrix_q.size(), m);
        for (int i = 0; i < 8; i++) matrix_q.insert(matrix_q.size(), rand_matrix());
        drain();

        // random phases, each under a different threshold
        for (int p = 0; p < 5; p++) begin
            set_threshold(thr_list[p]);
            if (p == 4) no_idle = 1;
            for (int i = 0; i < 160; i++) matrix_q.insert(matrix_q.size(), rand_matrix());
            if (p == 1) begin
                // sender holds off until everything in flight is back
                while (matrix_q.size() > 80) @(posedge aclk);
                hold_send = 1;
                while (s_valid || angles_q.size() > 0) @(posedge aclk);
                hold_send = 0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb_rotation_matrix_to_euler OK");
        end else begin
            $display("tb_rotation_matrix_to_euler NOT OK");
        end
        $finish;
    end
endmodule
